>>> rtl/hwu_pkg.sv
// Shared types and fixed-point constants for the Hebbian weight update block.
// No dependencies; used by hwu_qmul and hebbian_weight_update.
package hwu_pkg;

    // fixed formats
    localparam int MAXW_W = 23;     // max_weight register width
    localparam int FRAC_W = 16;     // Q8.16 fraction bits
    localparam int LIMB_W = 17;     // accumulator slice per partial product

    // Q8.16 constants
    localparam int Q_ONE           = 65536;
    localparam int Q_TWO           = 131072;
    localparam int Q_FOUR          = 262144;
    localparam int Q_FIVE          = 327680;
    localparam int Q_NEG_HUNDREDTH = -655;

    // configuration register map
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_WEIGHT = 1'b0,
        REG_RULE_MODE  = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_NEW = 1'b0,
        MODE_OLD = 1'b1
    } rule_mode_t;

endpackage

>>> rtl/hwu_qmul.sv
// Two-stage Q8.16 product unit: signed accumulator times signed factor,
// floored to 16 fraction bits and clipped to +-(2^(ACC_W-1) - 1). Uses hwu_pkg.
module hwu_qmul #(
    parameter int ACC_W = 51,
    parameter int FAC_W = 25
) (
    input  logic                    clk,
    input  logic [1:0]              en,
    input  logic signed [ACC_W-1:0] acc,
    input  logic signed [FAC_W-1:0] fac,
    output logic signed [ACC_W-1:0] res
);

    localparam int LIM_BITS = ACC_W - 1;
    localparam int NL       = (ACC_W + hwu_pkg::LIMB_W - 1) / hwu_pkg::LIMB_W;
    localparam int XW       = NL * hwu_pkg::LIMB_W;
    localparam int OP_W     = hwu_pkg::LIMB_W + 1;
    localparam int PP_W     = OP_W + FAC_W;
    localparam int SUM_W    = XW + FAC_W;
    localparam int SH_W     = SUM_W - hwu_pkg::FRAC_W;

    localparam logic signed [SH_W-1:0] POS_LIM = {{(SH_W-LIM_BITS){1'b0}}, {LIM_BITS{1'b1}}};
    localparam logic signed [SH_W-1:0] NEG_LIM = -POS_LIM;

    logic signed [XW-1:0]    acc_x;
    logic signed [OP_W-1:0]  op [NL];
    logic signed [PP_W-1:0]  pp_reg [NL];
    logic signed [SUM_W-1:0] sum;
    logic signed [SH_W-1:0]  sh;
    logic signed [SH_W-1:0]  clipped;
    logic signed [ACC_W-1:0] res_next;
    logic signed [ACC_W-1:0] res_reg;

    assign acc_x = XW'(acc);

    // lower slices are unsigned, the top slice carries the sign
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            if (i == NL - 1)
            begin
                op[i] = $signed({acc_x[i*hwu_pkg::LIMB_W + hwu_pkg::LIMB_W - 1],
                                 acc_x[i*hwu_pkg::LIMB_W +: hwu_pkg::LIMB_W]});
            end
            else
            begin
                op[i] = $signed({1'b0, acc_x[i*hwu_pkg::LIMB_W +: hwu_pkg::LIMB_W]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NL; i++)
            begin
                pp_reg[i] <= op[i] * fac;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NL; i++)
        begin
            sum = sum + (SUM_W'(pp_reg[i]) <<< (i * hwu_pkg::LIMB_W));
        end
        // arithmetic drop of the fraction bits is a floor
        sh = $signed(sum[SUM_W-1:hwu_pkg::FRAC_W]);
        if (sh > POS_LIM)
        begin
            clipped = POS_LIM;
        end
        else if (sh < NEG_LIM)
        begin
            clipped = NEG_LIM;
        end
        else
        begin
            clipped = sh;
        end
        res_next = $signed(clipped[ACC_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/hwu_chain.sv
// Four-factor product chain ((f0*f1)*f2)*f3 as three hwu_qmul units, six stages.
// Later factors are delayed to meet their product stage. Uses hwu_qmul.
module hwu_chain #(
    parameter int ACC_W = 51,
    parameter int FAC_W = 25
) (
    input  logic                    clk,
    input  logic [5:0]              en,
    input  logic signed [ACC_W-1:0] f0,
    input  logic signed [FAC_W-1:0] f1,
    input  logic signed [FAC_W-1:0] f2,
    input  logic signed [FAC_W-1:0] f3,
    output logic signed [ACC_W-1:0] res
);

    logic signed [FAC_W-1:0] f2_reg [2];
    logic signed [FAC_W-1:0] f3_reg [4];
    logic signed [ACC_W-1:0] prod0;
    logic signed [ACC_W-1:0] prod1;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f2_reg[0] <= f2;
            f3_reg[0] <= f3;
        end
        if (en[1])
        begin
            f2_reg[1] <= f2_reg[0];
            f3_reg[1] <= f3_reg[0];
        end
        if (en[2])
        begin
            f3_reg[2] <= f3_reg[1];
        end
        if (en[3])
        begin
            f3_reg[3] <= f3_reg[2];
        end
    end

    hwu_qmul #(.ACC_W(ACC_W), .FAC_W(FAC_W)) u_mul0 (
        .clk (clk),
        .en  (en[1:0]),
        .acc (f0),
        .fac (f1),
        .res (prod0)
    );

    hwu_qmul #(.ACC_W(ACC_W), .FAC_W(FAC_W)) u_mul1 (
        .clk (clk),
        .en  (en[3:2]),
        .acc (prod0),
        .fac (f2_reg[1]),
        .res (prod1)
    );

    hwu_qmul #(.ACC_W(ACC_W), .FAC_W(FAC_W)) u_mul2 (
        .clk (clk),
        .en  (en[5:4]),
        .acc (prod1),
        .fac (f3_reg[3]),
        .res (res)
    );

endmodule

>>> rtl/hebbian_weight_update.sv
// Top level of the per-synapse Hebbian weight update; uses hwu_pkg and hwu_chain.
// Front-end clamp and operand select, three product chains, sum and saturation.
//
// One link word enters per clock and one result word leaves per clock while out_stall
// is low; each word passes through two front-end stages (clamp to the maximum
// weight, operand select), six stages of three parallel product chains where every
// product is split into partial products of 17-bit slices, summed in the next stage,
// and two back-end stages (term sum, then sign, old-rule fix-up and saturation).
// Valid bits travel with each stage and a stage loads whenever it is empty or its
// successor moves, so a stalled output lets upstream bubbles close up before the
// input is stalled. The maximum weight below 5.0 is stored as 5.0 when written.
module hebbian_weight_update #(
    parameter int DATA_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_write_en,
    input  logic [hwu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hwu_pkg::MAXW_W-1:0]           cfg_data,
    // input words
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [DATA_WIDTH-1:0]         weight_in,
    input  logic signed [DATA_WIDTH-1:0]         act_pre,
    input  logic signed [DATA_WIDTH-1:0]         act_post,
    input  logic signed [DATA_WIDTH-1:0]         rate_hebb,
    input  logic signed [DATA_WIDTH-1:0]         rate_pre,
    input  logic signed [DATA_WIDTH-1:0]         rate_post,
    // result words
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [DATA_WIDTH-1:0]         weight_out,
    output logic                                 saturated
);

    localparam int N     = DATA_WIDTH;
    localparam int MW    = hwu_pkg::MAXW_W;
    localparam int NMAX  = (N > 24) ? N : 24;
    localparam int FAC_W = NMAX + 1;
    localparam int ACC_W = 75 - NMAX;
    localparam int SW    = ACC_W + 3;
    localparam int CMP_W = (N > MW) ? N : MW;

    localparam int NS    = 10;
    localparam int ST_CH = 2;
    localparam int ST_E1 = 8;
    localparam int ST_E2 = 9;

    localparam logic [MW-1:0]           M_FIVE   = MW'(hwu_pkg::Q_FIVE);
    localparam logic signed [FAC_W-1:0] F_ONE    = FAC_W'(hwu_pkg::Q_ONE);
    localparam logic signed [FAC_W-1:0] F_TWO    = FAC_W'(hwu_pkg::Q_TWO);
    localparam logic signed [FAC_W-1:0] F_FOUR   = FAC_W'(hwu_pkg::Q_FOUR);
    localparam logic signed [SW-1:0]    S_HUNDTH = SW'(hwu_pkg::Q_NEG_HUNDREDTH);
    localparam logic signed [SW-1:0]    OUT_MAX  = {{(SW-N+1){1'b0}}, {(N-1){1'b1}}};
    localparam logic signed [SW-1:0]    OUT_MIN  = ~OUT_MAX;
    localparam logic signed [N-1:0]     W_MAX    = {1'b0, {(N-1){1'b1}}};
    localparam logic signed [N-1:0]     W_MIN    = {1'b1, {(N-1){1'b0}}};

    // configuration
    logic [MW-1:0]       m_eff_reg;
    logic [MW-1:0]       m_eff_next;
    hwu_pkg::rule_mode_t mode_reg;

    // handshake
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] rdy;

    // front-end stage 1
    logic [N-1:0]            abs_w;
    logic [CMP_W-1:0]        abs_x;
    logic [MW-1:0]           wmag_next;
    logic [MW-1:0]           wmag1_reg;
    logic                    neg1_reg;
    logic signed [N-1:0]     a1_reg;
    logic signed [N-1:0]     b1_reg;
    logic signed [N-1:0]     h1_reg;
    logic signed [N-1:0]     p1_reg;
    logic signed [N-1:0]     q1_reg;

    // front-end stage 2
    logic signed [FAC_W-1:0] m_f;
    logic signed [FAC_W-1:0] w_f;
    logic signed [FAC_W-1:0] a_f;
    logic signed [FAC_W-1:0] b_f;
    logic signed [FAC_W-1:0] mw;
    logic signed [FAC_W-1:0] w2;
    logic signed [FAC_W-1:0] top;
    logic signed [FAC_W-1:0] w4;
    logic signed [FAC_W-1:0] m2;
    logic signed [FAC_W-1:0] top2;
    logic signed [FAC_W-1:0] bm1;
    logic signed [FAC_W-1:0] omb;
    logic signed [FAC_W-1:0] am1;
    logic signed [ACC_W-1:0] h_a;
    logic signed [ACC_W-1:0] p_a;
    logic signed [ACC_W-1:0] q_a;
    logic signed [ACC_W-1:0] hn;
    logic signed [ACC_W-1:0] h5n;
    logic                    is_old;
    logic signed [ACC_W-1:0] f0_next [3];
    logic signed [FAC_W-1:0] f1_next [3];
    logic signed [FAC_W-1:0] f2_next [3];
    logic signed [FAC_W-1:0] f3_next [3];
    logic signed [ACC_W-1:0] f0_reg [3];
    logic signed [FAC_W-1:0] f1_reg [3];
    logic signed [FAC_W-1:0] f2_reg [3];
    logic signed [FAC_W-1:0] f3_reg [3];
    logic [MW-1:0]           wmag2_reg;
    logic                    neg2_reg;

    // chain side band
    logic [MW-1:0]           wd_reg [6];
    logic                    negd_reg [6];
    logic signed [ACC_W-1:0] term [3];

    // back end
    logic signed [SW-1:0]    sum_next;
    logic signed [SW-1:0]    sum_reg;
    logic                    neg8_reg;
    logic signed [SW-1:0]    r;
    logic signed [N-1:0]     weight_out_next;
    logic                    saturated_next;
    logic signed [N-1:0]     weight_out_reg;
    logic                    saturated_reg;

    // ---------------- configuration ----------------
    assign m_eff_next = (cfg_data < M_FIVE) ? M_FIVE : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_eff_reg <= M_FIVE;
            mode_reg  <= hwu_pkg::MODE_NEW;
        end
        else if (cfg_write_en)
        begin
            case (hwu_pkg::cfg_reg_t'(cfg_index))
                hwu_pkg::REG_MAX_WEIGHT: m_eff_reg <= m_eff_next;
                hwu_pkg::REG_RULE_MODE:  mode_reg  <= hwu_pkg::rule_mode_t'(cfg_data[0]);
                default: ;
            endcase
        end
    end

    // ---------------- valid / stall ----------------
    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NS; i++)
        begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[NS-1];

    // ---------------- stage 1: clamp and split sign ----------------
    always_comb
    begin
        abs_w = weight_in[N-1] ? N'(-weight_in) : N'(weight_in);
        abs_x = CMP_W'(abs_w);
        wmag_next = (abs_x > CMP_W'(m_eff_reg)) ? m_eff_reg : MW'(abs_x);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            wmag1_reg <= wmag_next;
            neg1_reg  <= weight_in[N-1];
            a1_reg    <= act_pre;
            b1_reg    <= act_post;
            h1_reg    <= rate_hebb;
            p1_reg    <= rate_pre;
            q1_reg    <= rate_post;
        end
    end

    // ---------------- stage 2: factors and operand select ----------------
    always_comb
    begin
        m_f  = $signed(FAC_W'(m_eff_reg));
        w_f  = $signed(FAC_W'(wmag1_reg));
        a_f  = FAC_W'(a1_reg);
        b_f  = FAC_W'(b1_reg);
        mw   = m_f - w_f;
        w2   = w_f + F_TWO;
        top  = (w2 > m_f) ? m_f : w2;
        // min(w + 2, m) + 2 without the serial add
        w4   = w_f + F_FOUR;
        m2   = m_f + F_TWO;
        top2 = (w4 > m2) ? m2 : w4;
        bm1  = b_f - F_ONE;
        omb  = F_ONE - b_f;
        am1  = a_f - F_ONE;
        h_a  = ACC_W'(h1_reg);
        p_a  = ACC_W'(p1_reg);
        q_a  = ACC_W'(q1_reg);
        hn   = -h_a;
        h5n  = -((h_a <<< 2) + h_a);
        is_old = (mode_reg == hwu_pkg::MODE_OLD);

        // chain 0: learning-rate term on (M - w)
        f0_next[0] = (neg1_reg && !is_old) ? p_a : h_a;
        f1_next[0] = mw;
        f2_next[0] = a_f;
        f3_next[0] = neg1_reg ? omb : b_f;

        // chain 1: presynaptic / anti-Hebbian term
        if (neg1_reg)
        begin
            f0_next[1] = is_old ? h5n : hn;
        end
        else
        begin
            f0_next[1] = p_a;
        end
        if (is_old)
        begin
            f1_next[1] = w_f;
        end
        else
        begin
            f1_next[1] = neg1_reg ? top2 : top;
        end
        f2_next[1] = a_f;
        f3_next[1] = neg1_reg ? b_f : bm1;

        // chain 2: postsynaptic term, old rule on excitatory links only
        f0_next[2] = (is_old && !neg1_reg) ? q_a : '0;
        f1_next[2] = w_f;
        f2_next[2] = am1;
        f3_next[2] = b_f;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                f0_reg[k] <= f0_next[k];
                f1_reg[k] <= f1_next[k];
                f2_reg[k] <= f2_next[k];
                f3_reg[k] <= f3_next[k];
            end
            wmag2_reg <= wmag1_reg;
            neg2_reg  <= neg1_reg;
        end
    end

    // ---------------- product chains ----------------
    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_chain
            hwu_chain #(.ACC_W(ACC_W), .FAC_W(FAC_W)) u_chain (
                .clk (clk),
                .en  (rdy[ST_CH+5:ST_CH]),
                .f0  (f0_reg[g]),
                .f1  (f1_reg[g]),
                .f2  (f2_reg[g]),
                .f3  (f3_reg[g]),
                .res (term[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (rdy[ST_CH])
        begin
            wd_reg[0]   <= wmag2_reg;
            negd_reg[0] <= neg2_reg;
        end
        for (int k = 1; k < 6; k++)
        begin
            if (rdy[ST_CH+k])
            begin
                wd_reg[k]   <= wd_reg[k-1];
                negd_reg[k] <= negd_reg[k-1];
            end
        end
    end

    // ---------------- back end ----------------
    assign sum_next = $signed(SW'(wd_reg[5])) + SW'(term[0]) + SW'(term[1]) + SW'(term[2]);

    always_ff @(posedge clk)
    begin
        if (rdy[ST_E1])
        begin
            sum_reg  <= sum_next;
            neg8_reg <= negd_reg[5];
        end
    end

    always_comb
    begin
        r = neg8_reg ? -sum_reg : sum_reg;
        // old rule: excitatory must stay positive, inhibitory must stay negative
        if (mode_reg == hwu_pkg::MODE_OLD && (sum_reg[SW-1] || sum_reg == '0))
        begin
            r = neg8_reg ? S_HUNDTH : '0;
        end
        saturated_next = 1'b0;
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
            saturated_next = 1'b1;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
            saturated_next = 1'b1;
        end
        weight_out_next = $signed(r[N-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_E2])
        begin
            weight_out_reg <= weight_out_next;
            saturated_reg  <= saturated_next;
        end
    end

    assign weight_out = weight_out_reg;
    assign saturated  = saturated_reg;

    // ---------------- assertions ----------------
    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (weight_out == W_MAX || weight_out == W_MIN))
        else $error("saturation flag without extreme weight");

    a_m_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_eff_reg >= M_FIVE)
        else $error("maximum weight below 5.0");

    a_wmag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> wmag1_reg <= m_eff_reg)
        else $error("clamped weight exceeds maximum");

    a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted word not captured");

    a_hold_e1: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_E1] && !rdy[ST_E2] |=> valid_reg[ST_E1])
        else $error("blocked word lost ahead of output stage");

endmodule
